@@ hdl/tfl_pkg.sv @@
package tfl_pkg;

	// Table geometry and payload widths.
	localparam int unsigned ADDR_W  = 10;
	localparam int unsigned DEPTH   = 1 << ADDR_W;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned DEV_W   = 20;
	localparam int unsigned FLOW_W  = 48;
	localparam int unsigned PROD_W  = 2 * DATA_W;

	// Weighted sum of points in tenths, and its digit-serial divide by ten.
	localparam int unsigned ACC_W   = FLOW_W + 4;
	localparam int unsigned DIGIT_W = 4;

	// Quantile offsets stay below 2^15 for any deviation.
	localparam int unsigned MAG_W   = 11;
	localparam int unsigned OFF_W   = 15;
	localparam int unsigned PT_W    = 4;
	localparam int unsigned PT_MAX  = 9;

	// One table entry holds both fluxes.
	typedef struct packed {
		logic [DATA_W-1:0] flux;
		logic [DATA_W-1:0] max_flux;
	} tfl_entry_t;

	// Quantile magnitudes in thousandths, centre point first.
	function automatic logic [MAG_W-1:0] quant_mag(input logic [PT_W-1:0] i);
		logic [MAG_W-1:0] m;
		case (i)
			4'd1, 4'd5: m = 11'd253;
			4'd2, 4'd6: m = 11'd524;
			4'd3, 4'd7: m = 11'd842;
			4'd4, 4'd8: m = 11'd1283;
			default:    m = '0;
		endcase
		return m;
	endfunction

	// Points five through eight lie below the centre.
	function automatic logic quant_neg(input logic [PT_W-1:0] i);
		return (i >= 4'd5) && (i <= 4'd8);
	endfunction

endpackage

@@ hdl/tfl_table_mem.sv @@
module tfl_table_mem
	import tfl_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  tfl_entry_t        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output tfl_entry_t        rdata
);

	tfl_entry_t mem [0:DEPTH-1];
	tfl_entry_t rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/tfl_div10.sv @@
module tfl_div10
	import tfl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] dividend,
	output logic             done,
	output logic [FLOW_W-1:0] quotient
);

	localparam int unsigned STEPS = ACC_W / DIGIT_W;
	localparam int unsigned CNT_W = $clog2(STEPS + 1);

	logic [ACC_W-1:0]     dvd_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [2*DIGIT_W-1:0] part;
	logic [15:0]          recip;
	logic [DIGIT_W-1:0]   qd;
	logic [2*DIGIT_W-1:0] rest;

	// One digit per cycle: the partial remainder stays below 160, so a
	// reciprocal multiply by 205/2048 gives the exact quotient digit.
	always_comb begin
		part  = {rem_q, dvd_q[ACC_W-1 -: DIGIT_W]};
		recip = 16'(part) * 16'd205;
		qd    = recip[11 +: DIGIT_W];
		rest  = part - 8'(8'(qd) * 8'd10);
	end

	// The dividend shifts out at the top while quotient digits enter below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(STEPS);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[ACC_W-DIGIT_W-1:0], qd};
			rem_q <= rest[DIGIT_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q[FLOW_W-1:0];

endmodule

@@ hdl/transmissivity_flow_lookup.sv @@
// A write is stored when accepted and leaves busy low; a new transaction may follow at once.
// Interpolation (zero deviation): runs S_IRLO, S_IRHI and S_I1 to S_I7, then strobes flow.
// Quantile mode: each point runs S_QOFF, S_QADDR, S_QMF, S_QMM and S_QACC through the shared
// 32x32 multiplier and the table read port; the digit-serial divide by ten follows.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Reset clears the sequencer and strobe; table contents are undefined until written.
module transmissivity_flow_lookup
	import tfl_pkg::*;
#(
	parameter int unsigned MAX_INDEX       = 1000,
	parameter int unsigned QUANTILE_POINTS = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [ADDR_W-1:0] entry_index,
	input  logic [DATA_W-1:0] flux_value,
	input  logic [DATA_W-1:0] max_flux_value,
	input  logic [ADDR_W-1:0] deficit_index,
	input  logic [FRAC_W-1:0] deficit_fraction,
	input  logic [DEV_W-1:0]  deviation,
	input  logic [DATA_W-1:0] flux_gain,
	input  logic [DATA_W-1:0] patch_area,
	output logic              done,
	output logic [FLOW_W-1:0] flow
);

	localparam int unsigned TOP_INDEX = (MAX_INDEX > DEPTH - 1) ? DEPTH - 1 : MAX_INDEX;
	localparam logic [ADDR_W-1:0] TOP_IDX = ADDR_W'(TOP_INDEX);
	localparam int unsigned NPTS = (QUANTILE_POINTS > PT_MAX) ? PT_MAX : QUANTILE_POINTS;
	localparam logic [PT_W-1:0] LAST_PT = PT_W'(NPTS - 1);

	typedef enum logic [4:0] {
		S_IDLE,
		S_QOFF, S_QADDR, S_QMF, S_QMM, S_QACC, S_QDST, S_QDIV,
		S_IRLO, S_IRHI, S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_I7
	} state_t;

	state_t              state_q;
	logic                done_q;
	logic [FLOW_W-1:0]   flow_q;
	logic [ADDR_W-1:0]   cen_q;
	logic [ADDR_W-1:0]   nx_q;
	logic [DEV_W-1:0]    dev_q;
	logic [FRAC_W-1:0]   f_q;
	logic [DATA_W-1:0]   gain_q;
	logic [DATA_W-1:0]   area_q;
	logic [PT_W-1:0]     pt_q;
	logic [OFF_W-1:0]    off_q;
	logic [ACC_W-1:0]    acc_q;
	logic [PROD_W-1:0]   mul_q;
	logic [PROD_W-1:0]   p1_q;
	tfl_entry_t          lo_q;
	logic [FLOW_W:0]     sd_q;
	logic [FLOW_W:0]     sm_q;

	logic                accept;
	logic                mem_we;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;
	tfl_entry_t          mem_wdata;
	tfl_entry_t          mem_rdata;
	logic [DATA_W-1:0]   mul_a;
	logic [DATA_W-1:0]   mul_b;
	logic [ADDR_W-1:0]   cen_in;
	logic [ADDR_W-1:0]   pt_idx;
	logic [ADDR_W+5:0]   up_sum;
	logic [OFF_W-1:0]    dn_diff;
	logic [PROD_W-1:0]   pt_min;
	logic [FLOW_W-1:0]   pt_val;
	logic [ACC_W-1:0]    pt_wtd;
	logic [MAG_W+DEV_W-1:0] off_prod;
	logic                div_start;
	logic                div_done;
	logic [FLOW_W-1:0]   div_quo;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Write transactions go to the table in the cycle they are accepted.
	assign mem_we    = accept && !func;
	assign mem_wdata = '{flux: flux_value, max_flux: max_flux_value};

	// Centre index saturates to the top entry.
	assign cen_in = (deficit_index > TOP_IDX) ? TOP_IDX : deficit_index;

	// Quantile offset and clamped point index.
	always_comb begin
		off_prod = (MAG_W+DEV_W)'(quant_mag(pt_q)) * (MAG_W+DEV_W)'(dev_q);
		up_sum   = (ADDR_W+6)'(cen_q) + (ADDR_W+6)'(off_q);
		dn_diff  = OFF_W'(cen_q) - off_q;
		if (quant_neg(pt_q)) begin
			pt_idx = (off_q > OFF_W'(cen_q)) ? '0 : dn_diff[ADDR_W-1:0];
		end else begin
			pt_idx = (up_sum > (ADDR_W+6)'(TOP_IDX)) ? TOP_IDX : up_sum[ADDR_W-1:0];
		end
	end

	// Point value and its weight in tenths; the centre counts double.
	always_comb begin
		pt_min = (p1_q < mul_q) ? p1_q : mul_q;
		pt_val = pt_min[PROD_W-1 -: FLOW_W];
		pt_wtd = (pt_q == '0) ? {3'b0, pt_val, 1'b0} : {4'b0, pt_val};
	end

	// Table read port and shared multiplier operands by step.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = cen_q;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_QADDR: begin
				mem_re    = 1'b1;
				mem_raddr = pt_idx;
			end
			S_QMF: begin
				mul_a = gain_q;
				mul_b = mem_rdata.flux;
			end
			S_QMM: begin
				mul_a = area_q;
				mul_b = mem_rdata.max_flux;
			end
			S_IRLO: begin
				mem_re    = 1'b1;
				mem_raddr = cen_q;
			end
			S_IRHI: begin
				mem_re    = 1'b1;
				mem_raddr = nx_q;
			end
			S_I1: begin
				mul_a = mem_rdata.flux;
				mul_b = DATA_W'(f_q);
			end
			S_I2: begin
				mul_a = lo_q.flux;
				mul_b = DATA_W'(f_q);
			end
			S_I3: begin
				mul_a = mem_rdata.max_flux;
				mul_b = DATA_W'(f_q);
			end
			S_I4: begin
				mul_a = lo_q.max_flux;
				mul_b = DATA_W'(f_q);
			end
			S_I5: begin
				mul_a = gain_q;
				mul_b = sd_q[FRAC_W +: DATA_W];
			end
			S_I6: begin
				mul_a = area_q;
				mul_b = sm_q[FRAC_W +: DATA_W];
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == S_QDST);

	tfl_table_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (entry_index),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tfl_div10 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Shared multiplier, registered.
	always_ff @(posedge clk) begin
		mul_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// Sequencer with its registered result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && func) begin
						state_q <= (deviation != '0) ? S_QOFF : S_IRLO;
					end
				end
				S_QOFF:  state_q <= S_QADDR;
				S_QADDR: state_q <= S_QMF;
				S_QMF:   state_q <= S_QMM;
				S_QMM:   state_q <= S_QACC;
				S_QACC:  state_q <= (pt_q == LAST_PT) ? S_QDST : S_QOFF;
				S_QDST:  state_q <= S_QDIV;
				S_QDIV: begin
					if (div_done) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_IRLO:  state_q <= S_IRHI;
				S_IRHI:  state_q <= S_I1;
				S_I1:    state_q <= S_I2;
				S_I2:    state_q <= S_I3;
				S_I3:    state_q <= S_I4;
				S_I4:    state_q <= S_I5;
				S_I5:    state_q <= S_I6;
				S_I6:    state_q <= S_I7;
				S_I7: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the compute transaction.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cen_q  <= cen_in;
				nx_q   <= (cen_in < TOP_IDX) ? cen_in + 1'b1 : cen_in;
				dev_q  <= deviation;
				f_q    <= deficit_fraction;
				gain_q <= flux_gain;
				area_q <= patch_area;
				pt_q   <= '0;
				acc_q  <= '0;
			end
			S_QOFF: off_q <= off_prod[FRAC_W +: OFF_W];
			S_QMM:  p1_q  <= mul_q;
			S_QACC: begin
				acc_q <= acc_q + pt_wtd;
				pt_q  <= pt_q + 1'b1;
			end
			S_QDIV: begin
				if (div_done) begin
					flow_q <= div_quo;
				end
			end
			S_IRHI: lo_q <= mem_rdata;
			S_I2:   sd_q <= {1'b0, lo_q.flux, {FRAC_W{1'b0}}} + (FLOW_W+1)'(mul_q);
			S_I3:   sd_q <= sd_q - (FLOW_W+1)'(mul_q);
			S_I4:   sm_q <= {1'b0, lo_q.max_flux, {FRAC_W{1'b0}}} + (FLOW_W+1)'(mul_q);
			S_I5:   sm_q <= sm_q - (FLOW_W+1)'(mul_q);
			S_I6:   p1_q <= mul_q;
			S_I7:   flow_q <= pt_val;
			default: begin
				pt_q <= pt_q;
			end
		endcase
	end

	assign done = done_q;
	assign flow = flow_q;

	// The strobe comes only as the sequencer returns to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_IDLE))
		else $error("result strobe while a transaction is in flight");

	// A compute transaction never produces its result in the next cycle.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func) |=> !done)
		else $error("result strobe right after a compute transaction");

	// The divider result is handed to the output in the following cycle.
	a_div_out: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done && state_q == S_QDIV) |=> done)
		else $error("divider result not forwarded");

	// The table is read only by a compute transaction in flight.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> busy)
		else $error("table read while idle");

endmodule
